FILE: hw/rtl/rc4ks_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4ks_pkg
// Types and constants shared by the RC4 keystream engine.
// ----------------------------------------------------------------------------
package rc4ks_pkg;

    localparam int unsigned BYTE_W           = 8;
    localparam int unsigned PERM_DEPTH       = 256;
    localparam int unsigned PERM_AW          = 8;
    localparam int unsigned MAX_SEED_DEFAULT = 255;

    typedef enum logic [1:0] {
        KIND_IDENT = 2'd0,
        KIND_SEED  = 2'd1,
        KIND_SCHED = 2'd2,
        KIND_DATA  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_I,
        ST_RD_J,
        ST_WR_I,
        ST_WR_J,
        ST_PUT
    } state_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
        logic              start_of_buffer;
    } cmd_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              seed_dropped;
    } res_item_t;

    typedef struct packed {
        logic               en;
        logic [PERM_AW-1:0] addr;
        logic [BYTE_W-1:0]  data;
    } perm_wr_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rc4ks_perm_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4ks_perm_mem
// 256-byte permutation store with registered read and per-entry valid bits;
// an entry never written since the last clear reads as its own index.
// ----------------------------------------------------------------------------
module rc4ks_perm_mem (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire logic                            clear,
    input  wire rc4ks_pkg::perm_wr_t             wr,
    input  wire logic [rc4ks_pkg::PERM_AW-1:0]   rd_addr,
    output logic      [rc4ks_pkg::BYTE_W-1:0]    rd_data
);

    logic [rc4ks_pkg::BYTE_W-1:0]  mem [rc4ks_pkg::PERM_DEPTH];
    logic [rc4ks_pkg::PERM_DEPTH-1:0] vld_reg;
    logic                          rd_vld_reg;
    logic [rc4ks_pkg::BYTE_W-1:0]  rd_mem_reg;
    logic [rc4ks_pkg::PERM_AW-1:0] rd_addr_reg;

    always_ff @(posedge clk)
    begin
        rd_mem_reg  <= mem[rd_addr];
        rd_addr_reg <= rd_addr;
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[rd_addr];
            if (clear)
            begin
                vld_reg <= '0;
            end
            else if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_mem_reg : rd_addr_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/rc4ks_seed_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4ks_seed_mem
// Seed byte store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rc4ks_seed_mem #(
    parameter  int unsigned MAX_SEED_BYTES = rc4ks_pkg::MAX_SEED_DEFAULT,
    localparam int unsigned AW = (MAX_SEED_BYTES > 1) ? $clog2(MAX_SEED_BYTES) : 1
) (
    input  wire                               clk,
    input  wire logic                         wr_en,
    input  wire logic [AW-1:0]                wr_addr,
    input  wire logic [rc4ks_pkg::BYTE_W-1:0] wr_data,
    input  wire logic [AW-1:0]                rd_addr,
    output logic      [rc4ks_pkg::BYTE_W-1:0] rd_data
);

    logic [rc4ks_pkg::BYTE_W-1:0] mem [MAX_SEED_BYTES];

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/rc4_keystream_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_keystream_engine_top
// RC4 engine: identity reset, seed load, key schedule pass and keystream XOR
// over a single-port-write permutation memory.
// ----------------------------------------------------------------------------
//   channel | signals                   | beat
//   cmd     | cmd_valid, cmd_stall, cmd | kind, data_byte, start_of_buffer
//   res     | res_valid, res_stall, res | out_byte, seed_dropped
//
// Identity reset and seed byte go straight to the output step. A data byte steps
// through the read-i, read-j, two swap writes and the key read on the one memory.
// Schedule pass: read-i, read-j and two swap writes per entry; empty seed: skipped.
// No clearing pass after reset: valid bits restore the identity at once.
// A stalled result holds in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module rc4_keystream_engine_top #(
    parameter int unsigned MAX_SEED_BYTES = rc4ks_pkg::MAX_SEED_DEFAULT
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_stall,
    input  wire rc4ks_pkg::cmd_item_t  cmd,
    output logic                       res_valid,
    input  wire logic                  res_stall,
    output rc4ks_pkg::res_item_t       res
);

    localparam int unsigned SAW = (MAX_SEED_BYTES > 1) ? $clog2(MAX_SEED_BYTES) : 1;
    localparam int unsigned SCW = $clog2(MAX_SEED_BYTES + 1);

    rc4ks_pkg::state_t             state_reg, state_next;
    logic                          ks_reg, ks_next;
    logic [rc4ks_pkg::BYTE_W-1:0]  a_reg, a_next;
    logic [rc4ks_pkg::BYTE_W-1:0]  wj_reg, wj_next;
    logic [rc4ks_pkg::BYTE_W-1:0]  sa_reg, sa_next;
    logic [rc4ks_pkg::BYTE_W-1:0]  sb_reg, sb_next;
    logic [rc4ks_pkg::BYTE_W-1:0]  t_reg, t_next;
    logic [rc4ks_pkg::BYTE_W-1:0]  data_reg, data_next;
    logic [rc4ks_pkg::BYTE_W-1:0]  i_reg, i_next;
    logic [rc4ks_pkg::BYTE_W-1:0]  j_reg, j_next;
    logic [SAW-1:0]                kc_reg, kc_next;
    logic [SCW-1:0]                cnt_reg, cnt_next;
    rc4ks_pkg::res_item_t          res_reg, res_next;
    rc4ks_pkg::res_item_t          out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;

    logic                          perm_clear;
    rc4ks_pkg::perm_wr_t           perm_wr;
    logic [rc4ks_pkg::PERM_AW-1:0] perm_rd_addr;
    logic [rc4ks_pkg::BYTE_W-1:0]  perm_rd;
    logic                          seed_we;
    logic [SAW-1:0]                seed_rd_addr;
    logic [rc4ks_pkg::BYTE_W-1:0]  seed_rd;
    logic [rc4ks_pkg::BYTE_W-1:0]  seed_add;
    logic [rc4ks_pkg::BYTE_W-1:0]  key;
    logic [SCW-1:0]                kc_inc;

    rc4ks_perm_mem u_perm (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (perm_clear),
        .wr      (perm_wr),
        .rd_addr (perm_rd_addr),
        .rd_data (perm_rd)
    );

    rc4ks_seed_mem #(
        .MAX_SEED_BYTES (MAX_SEED_BYTES)
    ) u_seed (
        .clk     (clk),
        .wr_en   (seed_we),
        .wr_addr (cnt_reg[SAW-1:0]),
        .wr_data (cmd.data_byte),
        .rd_addr (seed_rd_addr),
        .rd_data (seed_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc4ks_pkg::ST_IDLE;
            ks_reg        <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ks_reg        <= ks_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        wj_reg   <= wj_next;
        sa_reg   <= sa_next;
        sb_reg   <= sb_next;
        t_reg    <= t_next;
        data_reg <= data_next;
        kc_reg   <= kc_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign seed_add = ks_reg ? '0 : seed_rd;
    assign kc_inc   = SCW'(kc_reg) + SCW'(1);

    always_comb
    begin
        if (t_reg == wj_reg)
        begin
            key = sa_reg;
        end
        else if (t_reg == a_reg)
        begin
            key = sb_reg;
        end
        else
        begin
            key = perm_rd;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ks_next        = ks_reg;
        a_next         = a_reg;
        wj_next        = wj_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        t_next         = t_reg;
        data_next      = data_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        kc_next        = kc_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && res_stall;
        perm_clear     = 1'b0;
        perm_wr        = '0;
        perm_rd_addr   = a_reg;
        seed_we        = 1'b0;
        seed_rd_addr   = kc_reg;
        cmd_stall      = (state_reg != rc4ks_pkg::ST_IDLE);

        unique case (state_reg)
            rc4ks_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    data_next = cmd.data_byte;
                    res_next  = '0;
                    unique case (cmd.kind)
                        rc4ks_pkg::KIND_IDENT:
                        begin
                            perm_clear = 1'b1;
                            state_next = rc4ks_pkg::ST_PUT;
                        end
                        rc4ks_pkg::KIND_SEED:
                        begin
                            if (cnt_reg < SCW'(MAX_SEED_BYTES))
                            begin
                                seed_we  = 1'b1;
                                cnt_next = cnt_reg + SCW'(1);
                            end
                            else
                            begin
                                res_next.seed_dropped = 1'b1;
                            end
                            state_next = rc4ks_pkg::ST_PUT;
                        end
                        rc4ks_pkg::KIND_SCHED:
                        begin
                            ks_next = 1'b0;
                            a_next  = '0;
                            wj_next = '0;
                            kc_next = '0;
                            if (cnt_reg == '0)
                            begin
                                state_next = rc4ks_pkg::ST_PUT;
                            end
                            else
                            begin
                                state_next = rc4ks_pkg::ST_RD_I;
                            end
                        end
                        rc4ks_pkg::KIND_DATA:
                        begin
                            ks_next    = 1'b1;
                            a_next     = (cmd.start_of_buffer ? '0 : i_reg) + 8'd1;
                            wj_next    = cmd.start_of_buffer ? '0 : j_reg;
                            state_next = rc4ks_pkg::ST_RD_I;
                        end
                        default:
                        begin
                            state_next = rc4ks_pkg::ST_PUT;
                        end
                    endcase
                end
            end
            rc4ks_pkg::ST_RD_I:
            begin
                perm_rd_addr = a_reg;
                state_next   = rc4ks_pkg::ST_RD_J;
            end
            rc4ks_pkg::ST_RD_J:
            begin
                sa_next      = perm_rd;
                wj_next      = wj_reg + perm_rd + seed_add;
                perm_rd_addr = wj_next;
                state_next   = rc4ks_pkg::ST_WR_I;
            end
            rc4ks_pkg::ST_WR_I:
            begin
                sb_next      = perm_rd;
                perm_wr.en   = 1'b1;
                perm_wr.addr = a_reg;
                perm_wr.data = perm_rd;
                t_next       = sa_reg + perm_rd;
                perm_rd_addr = t_next;
                state_next   = rc4ks_pkg::ST_WR_J;
            end
            rc4ks_pkg::ST_WR_J:
            begin
                perm_wr.en   = 1'b1;
                perm_wr.addr = wj_reg;
                perm_wr.data = sa_reg;
                if (ks_reg)
                begin
                    res_next.out_byte = data_reg ^ key;
                    i_next            = a_reg;
                    j_next            = wj_reg;
                    state_next        = rc4ks_pkg::ST_PUT;
                end
                else if (a_reg == 8'hFF)
                begin
                    cnt_next   = '0;
                    state_next = rc4ks_pkg::ST_PUT;
                end
                else
                begin
                    a_next     = a_reg + 8'd1;
                    kc_next    = (kc_inc == cnt_reg) ? '0 : kc_inc[SAW-1:0];
                    state_next = rc4ks_pkg::ST_RD_I;
                end
            end
            rc4ks_pkg::ST_PUT:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = rc4ks_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rc4ks_pkg::ST_IDLE;
            end
        endcase
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RC4 keystream engine. A software copy of the
// permutation, indices and seed store predicts each result beat: identity
// reset, seed load with overflow, key schedule passes (empty, chained, full
// seed) and keystream XOR with start-of-buffer restarts. Directed cases run
// first, then random seed/schedule/data sequences mixed with noise beats,
// under three sender/receiver idle profiles.
// ----------------------------------------------------------------------------
module tb;

    import rc4ks_pkg::*;

    localparam int unsigned SEED_CAP       = MAX_SEED_DEFAULT;
    localparam int          WATCHDOG_LIMIT = 20000;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_item_t cmd;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;
    int idle_cycles   = 0;

    logic [BYTE_W-1:0] perm_state [PERM_DEPTH];
    logic [BYTE_W-1:0] seed_bytes [PERM_DEPTH];
    logic [BYTE_W-1:0] key_i;
    logic [BYTE_W-1:0] key_j;
    int                seed_len;

    res_item_t expected_res [$];

    rc4_keystream_engine_top #(
        .MAX_SEED_BYTES(SEED_CAP)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
    begin
        res_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic void load_identity();
        for (int k = 0; k < PERM_DEPTH; k++)
        begin
            perm_state[k] = k[BYTE_W-1:0];
        end
    endfunction

    function automatic void swap_perm(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] t;
        t             = perm_state[a];
        perm_state[a] = perm_state[b];
        perm_state[b] = t;
    endfunction

    function automatic res_item_t rc4_step(input cmd_item_t c);
        res_item_t         r;
        logic [BYTE_W-1:0] j;
        logic [BYTE_W-1:0] ks_idx;
        r = '0;
        case (c.kind)
            KIND_IDENT:
            begin
                load_identity();
            end
            KIND_SEED:
            begin
                if (seed_len < SEED_CAP)
                begin
                    seed_bytes[seed_len] = c.data_byte;
                    seed_len++;
                end
                else
                begin
                    r.seed_dropped = 1'b1;
                end
            end
            KIND_SCHED:
            begin
                if (seed_len != 0)
                begin
                    j = '0;
                    for (int k = 0; k < PERM_DEPTH; k++)
                    begin
                        j = j + perm_state[k] + seed_bytes[k % seed_len];
                        swap_perm(k[BYTE_W-1:0], j);
                    end
                    seed_len = 0;
                end
            end
            default:
            begin
                if (c.start_of_buffer)
                begin
                    key_i = '0;
                    key_j = '0;
                end
                key_i = key_i + 8'd1;
                key_j = key_j + perm_state[key_i];
                swap_perm(key_i, key_j);
                ks_idx     = perm_state[key_i] + perm_state[key_j];
                r.out_byte = c.data_byte ^ perm_state[ks_idx];
            end
        endcase
        return r;
    endfunction

    // enter and leave just after a rising edge
    task automatic send_beat(input kind_t k, input logic [BYTE_W-1:0] b, input logic mark);
        cmd_item_t item;
        item.kind            = k;
        item.data_byte       = b;
        item.start_of_buffer = mark;
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        cmd       = item;
        cmd_valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (cmd_stall);
        expected_res.push_back(rc4_step(item));
    endtask

    task automatic send_data_run(input int n);
        logic [BYTE_W-1:0] b;
        for (int k = 0; k < n; k++)
        begin
            b = ($urandom_range(7) == 0) ? 8'h00 : BYTE_W'($urandom);
            send_beat(KIND_DATA, b, (k == 0) ? ($urandom_range(7) != 0) : ($urandom_range(15) == 0));
        end
    endtask

    task automatic test_directed_cases();
        send_beat(KIND_DATA, 8'h00, 1'b1);
        send_beat(KIND_DATA, 8'hFF, 1'b0);
        send_beat(KIND_DATA, 8'hA5, 1'b1);
        send_beat(KIND_SCHED, 8'hFF, 1'b1);
        send_beat(KIND_SEED, 8'h00, 1'b1);
        send_beat(KIND_SEED, 8'hFF, 1'b0);
        send_beat(KIND_SEED, 8'h5A, 1'b0);
        send_beat(KIND_IDENT, 8'hFF, 1'b1);
        send_beat(KIND_DATA, 8'h00, 1'b0);
        send_beat(KIND_SCHED, 8'h00, 1'b0);
        send_beat(KIND_SCHED, 8'h00, 1'b0);
        send_beat(KIND_SEED, 8'h13, 1'b0);
        send_beat(KIND_SCHED, 8'h00, 1'b0);
        send_beat(KIND_DATA, 8'h00, 1'b1);
        send_beat(KIND_DATA, 8'hFF, 1'b0);
        send_beat(KIND_DATA, 8'h00, 1'b0);
        send_beat(KIND_DATA, 8'h80, 1'b0);
        send_beat(KIND_DATA, 8'h01, 1'b0);
        send_beat(KIND_IDENT, 8'h00, 1'b0);
        send_beat(KIND_DATA, 8'h7F, 1'b0);
    endtask

    task automatic test_seed_overflow();
        send_beat(KIND_IDENT, BYTE_W'($urandom), 1'b0);
        for (int k = 0; k < SEED_CAP; k++)
        begin
            send_beat(KIND_SEED, BYTE_W'($urandom), 1'($urandom));
        end
        send_beat(KIND_SEED, 8'hFF, 1'b0);
        send_beat(KIND_SEED, 8'h00, 1'b1);
        send_beat(KIND_SEED, BYTE_W'($urandom), 1'b0);
        send_beat(KIND_SCHED, 8'h00, 1'b0);
        send_data_run(8);
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int seed_n;
        int data_n;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 80)
            begin
                if ($urandom_range(3) == 0)
                begin
                    send_beat(KIND_IDENT, BYTE_W'($urandom), 1'($urandom));
                    sent++;
                end
                if ($urandom_range(19) == 0)
                    seed_n = 0;
                else if ($urandom_range(9) == 0)
                    seed_n = $urandom_range(17, SEED_CAP);
                else
                    seed_n = $urandom_range(1, 16);
                for (int k = 0; k < seed_n; k++)
                begin
                    send_beat(KIND_SEED, BYTE_W'($urandom), 1'($urandom));
                end
                send_beat(KIND_SCHED, BYTE_W'($urandom), 1'($urandom));
                data_n = $urandom_range(1, 24);
                send_data_run(data_n);
                sent += seed_n + data_n + 1;
            end
            else
            begin
                send_beat(kind_t'($urandom_range(3)), BYTE_W'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_res.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: out_byte %02h seed_dropped %b",
                             res.out_byte, res.seed_dropped);
            end
            else
            begin
                if (res.out_byte !== expected_res[0].out_byte)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("out_byte mismatch: expected %02h actual %02h",
                                 expected_res[0].out_byte, res.out_byte);
                end
                if (res.seed_dropped !== expected_res[0].seed_dropped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("seed_dropped mismatch: expected %b actual %b",
                                 expected_res[0].seed_dropped, res.seed_dropped);
                end
                void'(expected_res.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        load_identity();
        key_i    = '0;
        key_j    = '0;
        seed_len = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        recv_idle_pct = 71;
        test_directed_cases();
        test_seed_overflow();
        test_random_traffic(460);

        send_idle_pct = 71;
        recv_idle_pct = 20;
        test_random_traffic(460);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(460);

        @(negedge clk);
        cmd_valid = 1'b0;
        while (expected_res.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/rc4ks_pkg.sv
hw/rtl/rc4ks_perm_mem.sv
hw/rtl/rc4ks_seed_mem.sv
hw/rtl/rc4_keystream_engine_top.sv
test/tb.sv
